/* src/sslr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo sample resampler package
// Shared constants and command codes for the linear resampler and its checker.
// ----------------------------------------------------------------------------
package sslr_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int PAD_DEF       = 4;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 32;
  localparam int STEP_W   = 24;
  localparam int FRAC_W   = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_SET     = 2'd2,
    FUNC_PRODUCE = 2'd3
  } func_t;

endpackage

`default_nettype wire

/* src/sslr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sslr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/stereo_sample_linear_resampler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Load, append and set commands, and inactive produce commands, pass from idle
// through the done state into the output register.
// An active produce runs two sample-store reads, then four passes through one
// shared 16x17 multiplier, each followed by an accumulate step, then saturation.
// A new transaction is taken once the result is in the output register; the result
// register waits for the consumer. Reset is synchronous and clears control only.
// ----------------------------------------------------------------------------
// Stereo sample linear resampler
// Stores stereo sample pairs and plays them back at a fractional position,
// interpolating linearly and accumulating with saturation onto caller values.
// ----------------------------------------------------------------------------
module stereo_sample_linear_resampler_top
  import sslr_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int PAD       = PAD_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_func,
  input  wire logic signed [SAMPLE_W-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_right_sample,
  input  wire logic [POS_W-1:0]           in_start_pos,
  input  wire logic [STEP_W-1:0]          in_step,
  input  wire logic signed [SAMPLE_W-1:0] in_add_left,
  input  wire logic signed [SAMPLE_W-1:0] in_add_right,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      out_left,
  output logic signed [SAMPLE_W-1:0]      out_right,
  output logic                            out_active,
  output logic [POS_W-1:0]                out_position
);

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int CMP_W = (ADDR_BITS + 2 > FRAC_W + 1) ? ADDR_BITS + 2 : FRAC_W + 1;
  localparam int ACC_W = 2 * SAMPLE_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_CAP,
    S_MUL,
    S_ACC,
    S_FIN,
    S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ADDR_BITS:0]          count_r, count_nxt;
  logic                        has_audio_r, has_audio_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [FRAC_W-1:0]           frac_r, frac_nxt;
  logic                        v0_r, v0_nxt, v1_r, v1_nxt;
  logic [ADDR_BITS-1:0]        a1_r, a1_nxt;
  logic [2*SAMPLE_W-1:0]       word0_r, word0_nxt, word1_r, word1_nxt;
  logic signed [SAMPLE_W-1:0]  add_l_r, add_l_nxt, add_r_r, add_r_nxt;
  logic [1:0]                  k_r, k_nxt;
  logic signed [ACC_W-1:0]     prod_r, prod_nxt;
  logic signed [ACC_W-1:0]     acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic signed [SAMPLE_W-1:0]  res_left_r, res_left_nxt, res_right_r, res_right_nxt;
  logic                        res_active_r, res_active_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0]  out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  logic                        out_active_r, out_active_nxt;
  logic [POS_W-1:0]            out_pos_r, out_pos_nxt;

  logic                        in_acc;
  logic [CMP_W-1:0]            idx0, idx1, pad_c, cnt_ext, len, off0, off1;
  logic                        go, v0, v1;
  logic                        ram_we;
  logic [ADDR_BITS-1:0]        ram_raddr;
  logic [2*SAMPLE_W-1:0]       ram_rdata;
  logic signed [SAMPLE_W-1:0]  mul_samp;
  logic [FRAC_W:0]             mul_wt;
  logic signed [ACC_W:0]       mul_full;
  logic signed [ACC_W-1:0]     rnd_l, rnd_r;
  logic signed [SAMPLE_W:0]    sum_l, sum_r;
  logic [POS_W:0]              pos_sum;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign idx0    = CMP_W'(pos_r[POS_W-1:FRAC_W]);
  assign idx1    = idx0 + CMP_W'(1);
  assign pad_c   = CMP_W'(PAD);
  assign cnt_ext = CMP_W'(count_r);
  assign len     = cnt_ext + CMP_W'(2 * PAD);
  assign off0    = idx0 - pad_c;
  assign off1    = idx1 - pad_c;
  assign v0      = (idx0 >= pad_c) && (off0 < cnt_ext);
  assign v1      = (idx1 >= pad_c) && (off1 < cnt_ext);
  assign go      = has_audio_r && (len != '0) && (idx0 < len - CMP_W'(1));

  assign ram_we    = in_acc && (func_t'(in_func) == FUNC_APPEND) && !count_r[ADDR_BITS];
  assign ram_raddr = (state_r == S_RD1) ? a1_r : off0[ADDR_BITS-1:0];

  sslr_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_BITS-1:0]),
    .wdata ({in_left_sample, in_right_sample}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (k_r)
      2'd0:    mul_samp = word0_r[2*SAMPLE_W-1:SAMPLE_W];
      2'd1:    mul_samp = word1_r[2*SAMPLE_W-1:SAMPLE_W];
      2'd2:    mul_samp = word0_r[SAMPLE_W-1:0];
      default: mul_samp = word1_r[SAMPLE_W-1:0];
    endcase
  end

  assign mul_wt   = k_r[0] ? {1'b0, frac_r} : ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, frac_r};
  assign mul_full = mul_samp * $signed({1'b0, mul_wt});

  assign rnd_l = acc_l_r + ACC_W'(32768);
  assign rnd_r = acc_r_r + ACC_W'(32768);
  assign sum_l = {add_l_r[SAMPLE_W-1], add_l_r} + rnd_l[ACC_W-1:FRAC_W];
  assign sum_r = {add_r_r[SAMPLE_W-1], add_r_r} + rnd_r[ACC_W-1:FRAC_W];
  assign pos_sum = {1'b0, pos_r} + (POS_W+1)'(step_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    has_audio_nxt  = has_audio_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    frac_nxt       = frac_r;
    v0_nxt         = v0_r;
    v1_nxt         = v1_r;
    a1_nxt         = a1_r;
    word0_nxt      = word0_r;
    word1_nxt      = word1_r;
    add_l_nxt      = add_l_r;
    add_r_nxt      = add_r_r;
    k_nxt          = k_r;
    prod_nxt       = prod_r;
    acc_l_nxt      = acc_l_r;
    acc_r_nxt      = acc_r_r;
    res_left_nxt   = res_left_r;
    res_right_nxt  = res_right_r;
    res_active_nxt = res_active_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_active_nxt = out_active_r;
    out_pos_nxt    = out_pos_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_left_nxt   = '0;
          res_right_nxt  = '0;
          res_active_nxt = 1'b0;
          state_nxt      = S_DONE;
          case (func_t'(in_func))
            FUNC_LOAD: begin
              count_nxt     = '0;
              has_audio_nxt = 1'b1;
            end
            FUNC_APPEND: begin
              if (!count_r[ADDR_BITS]) begin
                count_nxt = count_r + (ADDR_BITS+1)'(1);
              end
            end
            FUNC_SET: begin
              pos_nxt  = in_start_pos;
              step_nxt = in_step;
            end
            default: begin
              add_l_nxt     = in_add_left;
              add_r_nxt     = in_add_right;
              res_left_nxt  = in_add_left;
              res_right_nxt = in_add_right;
              frac_nxt      = pos_r[FRAC_W-1:0];
              v0_nxt        = v0;
              v1_nxt        = v1;
              a1_nxt        = off1[ADDR_BITS-1:0];
              if (go) begin
                state_nxt = S_RD1;
              end
            end
          endcase
        end
      end
      S_RD1: begin
        word0_nxt = v0_r ? ram_rdata : '0;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        word1_nxt = v1_r ? ram_rdata : '0;
        acc_l_nxt = '0;
        acc_r_nxt = '0;
        k_nxt     = 2'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = mul_full[ACC_W-1:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (k_r[1]) begin
          acc_r_nxt = acc_r_r + prod_r;
        end else begin
          acc_l_nxt = acc_l_r + prod_r;
        end
        k_nxt     = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (sum_l[SAMPLE_W] != sum_l[SAMPLE_W-1]) begin
          res_left_nxt = sum_l[SAMPLE_W] ? 16'sh8000 : 16'sh7fff;
        end else begin
          res_left_nxt = sum_l[SAMPLE_W-1:0];
        end
        if (sum_r[SAMPLE_W] != sum_r[SAMPLE_W-1]) begin
          res_right_nxt = sum_r[SAMPLE_W] ? 16'sh8000 : 16'sh7fff;
        end else begin
          res_right_nxt = sum_r[SAMPLE_W-1:0];
        end
        res_active_nxt = 1'b1;
        pos_nxt        = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_left_nxt   = res_left_r;
          out_right_nxt  = res_right_r;
          out_active_nxt = res_active_r;
          out_pos_nxt    = pos_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      has_audio_r <= 1'b0;
      pos_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      has_audio_r <= has_audio_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    frac_r       <= frac_nxt;
    v0_r         <= v0_nxt;
    v1_r         <= v1_nxt;
    a1_r         <= a1_nxt;
    word0_r      <= word0_nxt;
    word1_r      <= word1_nxt;
    add_l_r      <= add_l_nxt;
    add_r_r      <= add_r_nxt;
    k_r          <= k_nxt;
    prod_r       <= prod_nxt;
    acc_l_r      <= acc_l_nxt;
    acc_r_r      <= acc_r_nxt;
    res_left_r   <= res_left_nxt;
    res_right_r  <= res_right_nxt;
    res_active_r <= res_active_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
    out_active_r <= out_active_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_left     = out_left_r;
  assign out_right    = out_right_r;
  assign out_active   = out_active_r;
  assign out_position = out_pos_r;

endmodule

`default_nettype wire

/* src/sslr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo sample resampler checker
// Port-level assertions on sequencing and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module sslr_port_assertions
  import sslr_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [1:0]                 in_func,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] out_left,
  input wire logic signed [SAMPLE_W-1:0] out_right,
  input wire logic                       out_active,
  input wire logic [POS_W-1:0]           out_position
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right) &&
      $stable(out_active) && $stable(out_position))
    else $error("result changed while stalled");

  // The block works on one transaction at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while busy");

  // With no result pending, a non-produce command passes via the done state.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (func_t'(in_func) != FUNC_PRODUCE) && !out_valid
      |-> ##2 out_valid)
    else $error("command result late");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stereo_sample_linear_resampler_top sslr_port_assertions u_sslr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_func      (in_func),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_left     (out_left),
  .out_right    (out_right),
  .out_active   (out_active),
  .out_position (out_position)
);

`default_nettype wire
